[src/sorted_table_binary_search_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table binary search unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define STBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define STBS_ASSERT_NEVER(lbl, expr, msg) \
    `STBS_ASSERT(lbl, !(expr), msg)

`endif

[src/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Widths, defaults and operation codes shared by the search unit.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int STBS_TABLE_DEPTH = 1024;
    localparam int STBS_KEY_W       = 32;
    localparam int STBS_INDEX_W     = 10;
    localparam int STBS_OUT_DATA_W  = 16;

    localparam logic STBS_OP_APPEND = 1'b0;
    localparam logic STBS_OP_SEARCH = 1'b1;

endpackage

[src/stbs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/sorted_table_binary_search_unit.sv]
// ----------------------------------------------------------------------------
// Sorted table binary search unit
// Keeps a table of signed keys filled by appends and answers key searches.
// ----------------------------------------------------------------------------
// An append item is taken and writes its key at the end of the table; once
// the table is full further appends are dropped. A search item issues its
// first probe as it is taken and then makes one probe per cycle, the loop
// being set by the single key memory read port with its registered read:
// at most ceil(log2(count + 1)) probes. The result waits in an output
// register, so the next item is taken while it is still to be collected;
// if that register is still full, the result is held back and no item is
// taken until it frees. No clearing pass is needed after reset.
module sorted_table_binary_search_unit
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = STBS_TABLE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [STBS_KEY_W-1:0]      s_axis_tdata,   // [31:0] key
    input  logic                       s_axis_tuser,   // [0] operation
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [STBS_OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] index, [15:10] zero
    output logic                       m_axis_tuser    // [0] found
);

`include "sorted_table_binary_search_unit_macros.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_HOLD
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  lo_reg, lo_next;
    logic [CW-1:0]                  hi_reg, hi_next;
    logic [CW-1:0]                  mid_reg, mid_next;
    logic signed [STBS_KEY_W-1:0]   key_reg, key_next;
    logic                           pend_found_reg, pend_found_next;
    logic [STBS_INDEX_W-1:0]        pend_index_reg, pend_index_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_found_reg, out_found_next;
    logic [STBS_INDEX_W-1:0]        out_index_reg, out_index_next;

    logic                           s_fire;
    logic                           out_free;
    logic [CW-1:0]                  first_mid;
    logic [CW-1:0]                  mid_p1;
    logic                           lower_ok;
    logic                           upper_ok;
    logic [CW-1:0]                  mid_lower;
    logic [CW-1:0]                  mid_upper;
    logic signed [STBS_KEY_W-1:0]   probe;
    logic                           res_valid;
    logic                           res_found;
    logic [CW-1:0]                  res_mid;
    logic [CW+STBS_INDEX_W-1:0]     res_mid_ext;
    logic                           ram_wr_en;
    logic                           ram_rd_en;
    logic [AW-1:0]                  ram_rd_addr;
    logic [STBS_KEY_W-1:0]          ram_rd_data;

    stbs_ram #(
        .WIDTH (STBS_KEY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(AW)
    ) u_key_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(s_axis_tdata),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign first_mid = (count_reg - ONE_C) >> 1;
    assign mid_p1    = mid_reg + ONE_C;
    assign lower_ok  = lo_reg < mid_reg;
    assign upper_ok  = mid_p1 < hi_reg;
    assign mid_lower = lo_reg + ((mid_reg - lo_reg - ONE_C) >> 1);
    assign mid_upper = mid_p1 + ((hi_reg - mid_p1 - ONE_C) >> 1);
    assign probe     = $signed(ram_rd_data);

    assign res_mid_ext = {{STBS_INDEX_W{1'b0}}, res_mid};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        pend_found_next = pend_found_reg;
        pend_index_next = pend_index_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_index_next  = out_index_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = mid_reg[AW-1:0];
        res_valid       = 1'b0;
        res_found       = 1'b0;
        res_mid         = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_axis_tuser == STBS_OP_APPEND)
                    begin
                        if (count_reg < DEPTH_C)
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + ONE_C;
                        end
                    end
                    else
                    begin
                        key_next = $signed(s_axis_tdata);
                        if (count_reg == '0)
                        begin
                            res_valid = 1'b1;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = first_mid[AW-1:0];
                            lo_next     = '0;
                            hi_next     = count_reg;
                            mid_next    = first_mid;
                            state_next  = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (probe == key_reg)
                begin
                    res_valid = 1'b1;
                    res_found = 1'b1;
                    res_mid   = mid_reg;
                end
                else if (probe > key_reg)
                begin
                    if (lower_ok)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = mid_lower[AW-1:0];
                        hi_next     = mid_reg;
                        mid_next    = mid_lower;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
                else
                begin
                    if (upper_ok)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = mid_upper[AW-1:0];
                        lo_next     = mid_p1;
                        mid_next    = mid_upper;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = pend_found_reg;
                    out_index_next = pend_index_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_found_next = res_found;
                out_index_next = res_mid_ext[STBS_INDEX_W-1:0];
                state_next     = S_IDLE;
            end
            else
            begin
                pend_found_next = res_found;
                pend_index_next = res_mid_ext[STBS_INDEX_W-1:0];
                state_next      = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
            key_reg        <= '0;
            pend_found_reg <= 1'b0;
            pend_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_index_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            mid_reg        <= mid_next;
            key_reg        <= key_next;
            pend_found_reg <= pend_found_next;
            pend_index_reg <= pend_index_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_index_reg  <= out_index_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(STBS_OUT_DATA_W - STBS_INDEX_W){1'b0}}, out_index_reg};

    `STBS_ASSERT_NEVER(a_count_range, count_reg > DEPTH_C, "entry count beyond table depth")
    `STBS_ASSERT(a_range_open, (state_reg == S_CHECK) |-> (lo_reg < hi_reg && hi_reg <= count_reg), "probe range empty or beyond count")
    `STBS_ASSERT(a_mid_inside, (state_reg == S_CHECK) |-> (lo_reg <= mid_reg && mid_reg < hi_reg), "probe outside search range")
    `STBS_ASSERT(a_hold_blocked, (state_reg == S_HOLD) |-> out_valid_reg, "result held while output register free")

endmodule

[test/binary_search_checker.sv]
// ----------------------------------------------------------------------------
// Binary search result checker
// Watches both streams of the search unit. It keeps its own copy of the key
// table, works out the result of every accepted search and compares it,
// field by field, with the results that leave the unit, oldest first.
// ----------------------------------------------------------------------------
module binary_search_checker
    import stbs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [STBS_KEY_W-1:0]      s_axis_tdata,   // [31:0] key
    input  logic                       s_axis_tuser,   // [0] operation
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [STBS_OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] index, [15:10] zero
    input  logic                       m_axis_tuser,   // [0] found
    output int                         mismatch_count,
    output int                         results_owed
);

    typedef struct packed {
        logic                    found;
        logic [STBS_INDEX_W-1:0] index;
    } search_result_t;

    logic signed [STBS_KEY_W-1:0] key_store [STBS_TABLE_DEPTH];
    int                           stored_keys;
    search_result_t               owed_q[$];
    int                           fails;

    function automatic search_result_t binary_search(input logic signed [STBS_KEY_W-1:0] key);
        search_result_t r;
        int             lo;
        int             hi;
        int             mid;
        r.found = 1'b0;
        r.index = '0;
        lo = 0;
        hi = stored_keys - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key_store[mid] == key)
            begin
                r.found = 1'b1;
                r.index = mid[STBS_INDEX_W-1:0];
                break;
            end
            if (key_store[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        search_result_t want;
        if (!rst_n)
        begin
            stored_keys = 0;
            owed_q.delete();
            fails = 0;
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == STBS_OP_APPEND)
                begin
                    // Appends to a full table are dropped.
                    if (stored_keys < STBS_TABLE_DEPTH)
                    begin
                        key_store[stored_keys] = s_axis_tdata;
                        stored_keys++;
                    end
                end
                else
                    owed_q.push_back(binary_search(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with none expected: found=%0b data=%h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (m_axis_tuser !== want.found)
                    begin
                        fails++;
                        $display("%0t: found mismatch: expected %0b, got %0b",
                                 $time, want.found, m_axis_tuser);
                    end
                    if (m_axis_tdata !== {{(STBS_OUT_DATA_W-STBS_INDEX_W){1'b0}}, want.index})
                    begin
                        fails++;
                        $display("%0t: index mismatch: expected %0d, got data %h",
                                 $time, want.index, m_axis_tdata);
                    end
                end
            end
            mismatch_count <= fails;
            results_owed   <= owed_q.size();
        end
    end

endmodule

[test/tb_sorted_table_binary_search_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the sorted table binary search unit
// Drives appends and searches with random gaps on both streams, first a short
// directed run over the empty table and the key extremes, then ascending fills
// with duplicates, a few unsorted entries, a full table with dropped appends
// and searches for stored, neighbouring and random keys. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_unit;
    import stbs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [STBS_KEY_W-1:0]      s_axis_tdata;   // [31:0] key
    logic                       s_axis_tuser;   // [0] operation
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [STBS_OUT_DATA_W-1:0] m_axis_tdata;   // [9:0] index, [15:10] zero
    logic                       m_axis_tuser;   // [0] found
    int                         mismatch_count;
    int                         results_owed;
    int                         cycle_count;

    logic signed [STBS_KEY_W-1:0] loaded_keys[$];
    longint                       last_key;
    bit                           send_steady;
    bit                           sink_steady;

    sorted_table_binary_search_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    binary_search_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic offer_item(input logic op, input logic signed [STBS_KEY_W-1:0] key);
        int gap;
        if ($urandom_range(0, 23) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= key;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == STBS_OP_APPEND && loaded_keys.size() < STBS_TABLE_DEPTH)
            loaded_keys.push_back(key);
    endtask

    task automatic wait_for_results;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Ascending keys with occasional duplicates, the largest key at entry 999
    // and unsorted keys in the last entries of the table.
    function automatic logic signed [STBS_KEY_W-1:0] next_append_key();
        longint step;
        if (loaded_keys.size() > 999)
            return $urandom;
        if (loaded_keys.size() == 999)
            last_key = 64'sd2147483647;
        else
        begin
            step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8000000);
            last_key = last_key + step;
            if (last_key > 64'sd2147483647)
                last_key = 64'sd2147483647;
        end
        return last_key[STBS_KEY_W-1:0];
    endfunction

    function automatic logic signed [STBS_KEY_W-1:0] pick_search_key();
        int choice;
        logic signed [STBS_KEY_W-1:0] k;
        choice = $urandom_range(0, 9);
        if (loaded_keys.size() == 0 || choice > 6)
            return $urandom;
        k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        if (choice == 5)
            k = k + 1;
        else if (choice == 6)
            k = k - 1;
        return k;
    endfunction

    initial
    begin : results_sink
        int waits;
        int taken;
        int hold;
        waits = 0;
        taken = 0;
        hold  = 0;
        sink_steady = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else if (waits > 0)
            begin
                m_axis_tready <= 1'b0;
                waits--;
            end
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                taken++;
                if (taken == 40 || taken == 100)
                    hold = 400;
                if ($urandom_range(0, 23) == 0)
                    sink_steady = !sink_steady;
                waits = sink_steady ? 0 : $urandom_range(0, 3);
            end
        end
    end

    initial
    begin : stimulus
        int n;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = STBS_OP_APPEND;
        rst_n         = 1'b0;
        cycle_count   = 0;
        send_steady   = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Empty table, key extremes, duplicates and missing neighbours.
        offer_item(STBS_OP_SEARCH, 32'sd0);
        offer_item(STBS_OP_SEARCH, 32'h8000_0000);
        offer_item(STBS_OP_APPEND, 32'h8000_0000);
        offer_item(STBS_OP_SEARCH, 32'h8000_0000);
        offer_item(STBS_OP_SEARCH, 32'h7FFF_FFFF);
        offer_item(STBS_OP_SEARCH, 32'sd0);
        offer_item(STBS_OP_APPEND, -32'sd5);
        offer_item(STBS_OP_APPEND, -32'sd5);
        offer_item(STBS_OP_APPEND, 32'sd0);
        offer_item(STBS_OP_APPEND, 32'sd7);
        offer_item(STBS_OP_SEARCH, -32'sd5);
        offer_item(STBS_OP_SEARCH, 32'sd0);
        offer_item(STBS_OP_SEARCH, 32'sd7);
        offer_item(STBS_OP_SEARCH, 32'sd6);
        offer_item(STBS_OP_SEARCH, -32'sd6);
        offer_item(STBS_OP_SEARCH, 32'h7FFF_FFFF);
        offer_item(STBS_OP_SEARCH, 32'h8000_0000);
        last_key = 7;
        wait_for_results();

        while (loaded_keys.size() < STBS_TABLE_DEPTH)
        begin
            if ($urandom_range(0, 19) != 0)
                offer_item(STBS_OP_APPEND, next_append_key());
            else
                offer_item(STBS_OP_SEARCH, pick_search_key());
            if (loaded_keys.size() == 500)
                wait_for_results();
        end

        // Table full: appends are dropped from here on.
        for (n = 0; n < 80; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                offer_item(STBS_OP_APPEND, $urandom);
            else
                offer_item(STBS_OP_SEARCH, pick_search_key());
        end
        wait_for_results();
        offer_item(STBS_OP_APPEND, 32'h8000_0000);
        offer_item(STBS_OP_APPEND, 32'h7FFF_FFFF);
        offer_item(STBS_OP_SEARCH, 32'h7FFF_FFFF);
        offer_item(STBS_OP_SEARCH, 32'h8000_0000);
        offer_item(STBS_OP_SEARCH, loaded_keys[STBS_TABLE_DEPTH-1]);
        offer_item(STBS_OP_SEARCH, loaded_keys[0]);

        wait_for_results();
        repeat (30) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sorted_table_binary_search_unit.f]
+incdir+src
src/stbs_pkg.sv
src/stbs_ram.sv
src/sorted_table_binary_search_unit.sv
test/binary_search_checker.sv
test/tb_sorted_table_binary_search_unit.sv
